// ===== sv/pie_pkg.sv =====
`default_nettype none
package pie_pkg;

	localparam int MAX_SIZE_DEF = 16;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_DATA_W  = 31;
	localparam int CFG_IDX_W   = 2;

	localparam int DIV_DVD_W = 60;
	localparam int DIV_DSR_W = 32;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	localparam logic [4:0]  SIZE_RST = 5'd16;
	localparam logic [15:0] MAXIT_RST = 16'd100;
	localparam logic [30:0] PREC_RST = 31'd1074;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_START = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_SIZE  = 2'd0,
		CFG_MAXIT = 2'd1,
		CFG_PREC  = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SEED,
		ST_MAC_RD,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_MAC_WR,
		ST_NORM,
		ST_SQ_RD,
		ST_SQ_MAG,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_DIV_RD,
		ST_DIV_MAG,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DIV_WR,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_CHECK,
		ST_OUT_RD,
		ST_OUT_LOAD,
		ST_OUT_HOLD
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_DVD_W-1:0] dividend;
		logic [DIV_DSR_W-1:0] divisor;
	} div_req_t;

endpackage
`default_nettype wire

// ===== sv/power_iteration_eigenvector.sv =====
// Load item (tuser = write): stores one element, no result; start item: seeds the
// vector, then per pass a multiply-accumulate, up to 28 normalizing shifts, a
// shared multiplier for products and squares, a square root, a divide per
// component through the divider and one for the mean. Not ready meanwhile.
// Then each component is emitted in turn, held until the sink is ready.
// Reset (arst_n low): idle, registers back to size 16, limit 100, precision 1074.
`default_nettype none
module power_iteration_eigenvector #(
	parameter int MAX_SIZE = pie_pkg::MAX_SIZE_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// row_index[3:0], col_index[7:4], element_value[39:8]
	input  wire logic [pie_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// opcode[0]
	input  wire logic [0:0]                         s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// component_index[3:0], component_value[35:4], passes_run[51:36], zero fill
	output logic [pie_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	output logic                                    m_axis_tlast,
	// converged[0], zero_norm[1]
	output logic [1:0]                              m_axis_tuser,
	input  wire logic                               cfg_we,
	input  wire logic [pie_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pie_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import pie_pkg::*;

	localparam int IW    = $clog2(MAX_SIZE);
	localparam int AW    = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int ACCW  = 47 + IW;
	localparam int DIFFW = 33 + IW;
	localparam int SQW   = 58 + IW;

	state_t state_q, state_d;

	logic [4:0]  size_q;
	logic [15:0] maxit_q;
	logic [30:0] prec_q;

	logic [IW-1:0] nm1_q, nm1_d;
	logic [IW-1:0] i_q, j_q;
	logic [15:0]   pc_q;
	logic          conv_q, zero_q;

	logic signed [31:0] mat_mem [MAX_SIZE*MAX_SIZE];
	logic signed [31:0] cur_mem [MAX_SIZE];
	logic signed [47:0] prod_mem [MAX_SIZE];
	logic signed [31:0] mat_rd_q, cur_rd_q;
	logic signed [47:0] prod_rd_q;
	logic [AW-1:0]      mat_raddr, mat_waddr;
	logic [IW-1:0]      cur_raddr;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_full;
	logic signed [63:0] mul_q;
	logic signed [63:0] rnd;
	logic signed [63:0] term;

	logic signed [ACCW-1:0]  acc_q;
	logic signed [47:0]      sat;
	logic [47:0]             sat_mag;
	logic [47:0]             maxm_q;
	logic [4:0]              up_q, dn_q;
	logic [47:0]             prod_mag;
	logic [63:0]             scaled;
	logic [28:0]             smag_q;
	logic                    neg_q;
	logic [SQW-1:0]          sumsq_q;
	logic signed [DIFFW-1:0] diff_q;
	logic [DIFFW-1:0]        diff_abs;
	logic signed [31:0]      nv;

	logic        sq_start, sq_done;
	logic [31:0] norm;
	div_req_t    div_req;
	logic        div_done;
	logic [DIV_DVD_W-1:0] quot;

	logic       in_acc, is_start;
	logic       i_last, j_last;
	logic       pass_init;

	logic [3:0]         out_idx_q;
	logic signed [31:0] out_val_q;
	logic               out_last_q, ovalid_q;

	pie_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (64'(sumsq_q)),
		.done   (sq_done),
		.root   (norm)
	);

	pie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (quot)
	);

	function automatic logic pass_ok(input logic [15:0] cnt, input logic [15:0] lim);
		pass_ok = (17'(cnt) + 17'd1) < 17'(lim);
	endfunction

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign is_start = (s_axis_tuser[0] == OP_START);
	assign i_last   = (i_q == nm1_q);
	assign j_last   = (j_q == nm1_q);

	always_comb begin
		if (size_q == 5'd0)
			nm1_d = '0;
		else if (32'(size_q) > 32'(MAX_SIZE))
			nm1_d = IW'(MAX_SIZE - 1);
		else
			nm1_d = IW'(size_q - 5'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RST;
			maxit_q <= MAXIT_RST;
			prec_q  <= PREC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE:  size_q  <= cfg_wdata[4:0];
				CFG_MAXIT: maxit_q <= cfg_wdata[15:0];
				CFG_PREC:  prec_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// memories
	assign mat_waddr = AW'(AW'(s_axis_tdata[3:0]) * AW'(MAX_SIZE)) + AW'(s_axis_tdata[7:4]);
	assign mat_raddr = AW'(AW'(i_q) * AW'(MAX_SIZE)) + AW'(j_q);
	assign cur_raddr = (state_q == ST_MAC_RD) ? j_q : i_q;

	always_ff @(posedge clk) begin
		if (in_acc && !is_start && (32'(s_axis_tdata[3:0]) < 32'(MAX_SIZE))
		    && (32'(s_axis_tdata[7:4]) < 32'(MAX_SIZE)))
			mat_mem[mat_waddr] <= s_axis_tdata[39:8];
		mat_rd_q <= mat_mem[mat_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEED)
			cur_mem[i_q] <= ONE_Q30;
		else if (state_q == ST_DIV_WR)
			cur_mem[i_q] <= nv;
		cur_rd_q <= cur_mem[cur_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MAC_WR)
			prod_mem[i_q] <= sat;
		prod_rd_q <= prod_mem[i_q];
	end

	// shared multiplier
	always_comb begin
		if (state_q == ST_MAC_MUL) begin
			mul_a = 33'(mat_rd_q);
			mul_b = 33'(cur_rd_q);
		end else begin
			mul_a = $signed({4'b0000, smag_q});
			mul_b = $signed({4'b0000, smag_q});
		end
	end
	assign mul_full = mul_a * mul_b;

	always_ff @(posedge clk) begin
		mul_q <= mul_full[63:0];
	end

	assign rnd  = mul_q + 64'sd32768;
	assign term = rnd >>> 16;

	always_comb begin
		if ((&acc_q[ACCW-1:47]) || !(|acc_q[ACCW-1:47]))
			sat = acc_q[47:0];
		else if (acc_q[ACCW-1])
			sat = {1'b1, 47'd0};
		else
			sat = {1'b0, {47{1'b1}}};
	end
	assign sat_mag  = sat[47] ? 48'(-sat) : 48'(sat);
	assign prod_mag = prod_rd_q[47] ? 48'(-prod_rd_q) : 48'(prod_rd_q);
	assign scaled   = (64'(prod_mag) << up_q) >> dn_q;
	assign nv       = neg_q ? -$signed(quot[31:0]) : $signed(quot[31:0]);
	assign diff_abs = diff_q[DIFFW-1] ? DIFFW'(-diff_q) : DIFFW'(diff_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		sq_start  = 1'b0;
		pass_init = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = (DIV_DVD_W'(smag_q) << 30) + DIV_DVD_W'(norm >> 1);
		div_req.divisor  = norm;
		unique case (state_q)
			ST_IDLE:
				if (in_acc && is_start)
					state_d = ST_SEED;
			ST_SEED:
				if (i_last) begin
					if (pass_ok(16'd0, maxit_q)) begin
						pass_init = 1'b1;
						state_d   = ST_MAC_RD;
					end else begin
						state_d = ST_OUT_RD;
					end
				end
			ST_MAC_RD:  state_d = ST_MAC_MUL;
			ST_MAC_MUL: state_d = ST_MAC_ACC;
			ST_MAC_ACC: state_d = j_last ? ST_MAC_WR : ST_MAC_RD;
			ST_MAC_WR:  state_d = i_last ? ST_NORM : ST_MAC_RD;
			ST_NORM:
				if (maxm_q == 48'd0)
					state_d = ST_OUT_RD;
				else if (maxm_q >= 48'h0000_1000_0000 && maxm_q < 48'h0000_2000_0000)
					state_d = ST_SQ_RD;
			ST_SQ_RD:   state_d = ST_SQ_MAG;
			ST_SQ_MAG:  state_d = ST_SQ_MUL;
			ST_SQ_MUL:  state_d = ST_SQ_ACC;
			ST_SQ_ACC:  state_d = i_last ? ST_SQRT_GO : ST_SQ_RD;
			ST_SQRT_GO: begin
				sq_start = 1'b1;
				state_d  = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT:
				if (sq_done)
					state_d = ST_DIV_RD;
			ST_DIV_RD:  state_d = ST_DIV_MAG;
			ST_DIV_MAG: state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT:
				if (div_done)
					state_d = ST_DIV_WR;
			ST_DIV_WR:  state_d = i_last ? ST_MEAN_GO : ST_DIV_RD;
			ST_MEAN_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_DVD_W'(diff_abs);
				div_req.divisor  = DIV_DSR_W'(nm1_q) + DIV_DSR_W'(1);
				state_d          = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT:
				if (div_done)
					state_d = ST_CHECK;
			ST_CHECK:
				if (quot <= DIV_DVD_W'(prec_q)) begin
					state_d = ST_OUT_RD;
				end else if (pass_ok(pc_q + 16'd1, maxit_q)) begin
					pass_init = 1'b1;
					state_d   = ST_MAC_RD;
				end else begin
					state_d = ST_OUT_RD;
				end
			ST_OUT_RD:   state_d = ST_OUT_LOAD;
			ST_OUT_LOAD: state_d = ST_OUT_HOLD;
			ST_OUT_HOLD:
				if (m_axis_tready)
					state_d = i_last ? ST_IDLE : ST_OUT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm1_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			pc_q     <= '0;
			conv_q   <= 1'b0;
			zero_q   <= 1'b0;
			ovalid_q <= 1'b0;
			up_q     <= '0;
			dn_q     <= '0;
		end else begin
			if (pass_init) begin
				up_q <= '0;
				dn_q <= '0;
			end
			unique case (state_q)
				ST_IDLE:
					if (in_acc && is_start) begin
						nm1_q  <= nm1_d;
						i_q    <= '0;
						j_q    <= '0;
						pc_q   <= '0;
						conv_q <= 1'b0;
						zero_q <= 1'b0;
					end
				ST_SEED:
					i_q <= i_last ? '0 : i_q + 1'b1;
				ST_MAC_ACC:
					j_q <= j_last ? '0 : j_q + 1'b1;
				ST_MAC_WR:
					i_q <= i_last ? '0 : i_q + 1'b1;
				ST_NORM:
					if (maxm_q == 48'd0) begin
						zero_q <= 1'b1;
						pc_q   <= pc_q + 16'd1;
					end else if (maxm_q < 48'h0000_1000_0000) begin
						up_q <= up_q + 5'd1;
					end else if (maxm_q >= 48'h0000_2000_0000) begin
						dn_q <= dn_q + 5'd1;
					end
				ST_SQ_ACC:
					i_q <= i_last ? '0 : i_q + 1'b1;
				ST_DIV_WR:
					i_q <= i_last ? '0 : i_q + 1'b1;
				ST_CHECK: begin
					pc_q <= pc_q + 16'd1;
					if (quot <= DIV_DVD_W'(prec_q))
						conv_q <= 1'b1;
				end
				ST_OUT_LOAD:
					ovalid_q <= 1'b1;
				ST_OUT_HOLD:
					if (m_axis_tready) begin
						ovalid_q <= 1'b0;
						i_q      <= i_last ? '0 : i_q + 1'b1;
					end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pass_init) begin
			acc_q   <= '0;
			maxm_q  <= '0;
			sumsq_q <= '0;
			diff_q  <= '0;
		end
		unique case (state_q)
			ST_MAC_ACC:
				acc_q <= acc_q + ACCW'(term);
			ST_MAC_WR: begin
				acc_q <= '0;
				if (sat_mag > maxm_q)
					maxm_q <= sat_mag;
			end
			ST_NORM:
				if (maxm_q != 48'd0) begin
					if (maxm_q < 48'h0000_1000_0000)
						maxm_q <= maxm_q << 1;
					else if (maxm_q >= 48'h0000_2000_0000)
						maxm_q <= maxm_q >> 1;
				end
			ST_SQ_MAG, ST_DIV_MAG: begin
				smag_q <= scaled[28:0];
				neg_q  <= prod_rd_q[47];
			end
			ST_SQ_ACC:
				sumsq_q <= sumsq_q + SQW'(mul_q);
			ST_DIV_WR:
				diff_q <= diff_q + DIFFW'(cur_rd_q) - DIFFW'(nv);
			ST_OUT_LOAD: begin
				out_idx_q  <= 4'(i_q);
				out_val_q  <= cur_rd_q;
				out_last_q <= i_last;
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {4'b0000, pc_q, out_val_q, out_idx_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {zero_q, conv_q};
endmodule
`default_nettype wire

// ===== sv/pie_div.sv =====
`default_nettype none
module pie_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pie_pkg::div_req_t               req,
	output logic                                 done,
	output logic [pie_pkg::DIV_DVD_W-1:0]        quot
);
	import pie_pkg::*;

	localparam int CNT_W = $clog2(DIV_DVD_W + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_DSR_W:0]   trial;
	logic [DIV_DSR_W:0]   sub;
	logic                 ge;

	// one quotient bit per cycle; quotient shifts in behind the dividend
	assign trial = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign sub   = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? sub[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
endmodule
`default_nettype wire

// ===== sv/pie_isqrt.sv =====
`default_nettype none
module pie_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] x,
	output logic             done,
	output logic [31:0]      root
);
	import pie_pkg::*;

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] r2;
	logic [35:0] trial;
	logic [35:0] sub;
	logic        ge;

	// two radicand bits per cycle, one root bit
	assign r2    = {rem_q, x_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign sub   = r2 - trial;
	assign ge    = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			rem_q  <= ge ? sub[33:0] : r2[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== sv/pie_checker.sv =====
`default_nettype none
module pie_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [pie_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input wire logic                              m_axis_tlast,
	input wire logic [1:0]                        m_axis_tuser
);
	import pie_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// no intake while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while result pending");

	// after the last component the block returns to intake
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
		else $error("run did not end after last item");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("converged and zero norm both set");

	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
		else $error("intake reopened before last item");
endmodule

bind power_iteration_eigenvector pie_checker u_pie_checker (.*);
`default_nettype wire

// ===== bench/pie_checker.sv =====
`timescale 1ns / 100ps
module tb_pie_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [39:0] s_tdata,
	input  wire logic [0:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata,
	input  wire logic        m_tlast,
	input  wire logic [1:0]  m_tuser,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_wdata,
	output int               mismatches,
	output int               pending
);
	import pie_pkg::*;

	typedef struct {
		logic [3:0]  idx;
		logic [31:0] value;
		logic        last;
		logic        conv;
		logic [15:0] passes;
		logic        zero;
	} component_t;

	component_t          eigen_q[$];
	logic signed [31:0]  mat[16][16];
	logic signed [31:0]  vec[16];
	logic [4:0]          size_reg;
	logic [15:0]         maxit_reg;
	logic [30:0]         prec_reg;

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// 0 keeps going, 1 converged, 2 zero norm
	function automatic int eigen_pass(int n);
		longint          acc, lim, nv, diff, mean;
		longint unsigned mag[16];
		longint unsigned maxm, sumsq, norm, q, m, amean;
		logic            neg[16];
		int              up, down;
		lim = 64'sd1 <<< 47;
		maxm = 0;
		sumsq = 0;
		diff = 0;
		for (int i = 0; i < n; i++) begin
			acc = 0;
			for (int j = 0; j < n; j++)
				acc += (longint'(mat[i][j]) * longint'(vec[j]) + 32768) >>> 16;
			if (acc > lim - 1) acc = lim - 1;
			if (acc < -lim) acc = -lim;
			neg[i] = acc < 0;
			mag[i] = acc < 0 ? -acc : acc;
			if (mag[i] > maxm) maxm = mag[i];
		end
		if (maxm == 0)
			return 2;
		up = 0;
		down = 0;
		m = maxm;
		while (m < (64'd1 << 28)) begin m <<= 1; up++; end
		while (m >= (64'd1 << 29)) begin m >>= 1; down++; end
		for (int i = 0; i < n; i++) begin
			mag[i] = (mag[i] << up) >> down;
			sumsq += mag[i] * mag[i];
		end
		norm = isqrt(sumsq);
		for (int i = 0; i < n; i++) begin
			q = ((mag[i] << 30) + (norm >> 1)) / norm;
			nv = neg[i] ? -longint'(q) : longint'(q);
			diff += longint'(vec[i]) - nv;
			vec[i] = nv[31:0];
		end
		mean = diff / longint'(n);
		amean = mean < 0 ? -mean : mean;
		return amean <= prec_reg ? 1 : 0;
	endfunction

	task automatic predict_eigenvector();
		int          n, r;
		logic [15:0] passes;
		logic        conv, zero;
		component_t  c;
		n = size_reg == 0 ? 1 : (size_reg > 16 ? 16 : size_reg);
		for (int i = 0; i < 16; i++)
			vec[i] = ONE_Q30;
		passes = 0;
		conv = 0;
		zero = 0;
		for (int it = 1; it < maxit_reg; it++) begin
			r = eigen_pass(n);
			passes++;
			if (r == 1) begin conv = 1; break; end
			if (r == 2) begin zero = 1; break; end
		end
		for (int i = 0; i < n; i++) begin
			c.idx = i[3:0];
			c.value = vec[i];
			c.last = i == n - 1;
			c.conv = conv;
			c.passes = passes;
			c.zero = zero;
			eigen_q.push_back(c);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		component_t c;
		if (!arst_n) begin
			size_reg = SIZE_RST;
			maxit_reg = MAXIT_RST;
			prec_reg = PREC_RST;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIZE:  size_reg = cfg_wdata[4:0];
					CFG_MAXIT: maxit_reg = cfg_wdata[15:0];
					CFG_PREC:  prec_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (eigen_q.size() == 0) begin
					$error("unexpected component %0d", m_tdata[3:0]);
					mismatches++;
				end else begin
					c = eigen_q.pop_front();
					if (m_tdata[3:0] !== c.idx) begin
						$error("component_index exp %0d got %0d", c.idx, m_tdata[3:0]);
						mismatches++;
					end
					if (m_tdata[35:4] !== c.value) begin
						$error("component_value exp %0h got %0h", c.value, m_tdata[35:4]);
						mismatches++;
					end
					if (m_tlast !== c.last) begin
						$error("last_component exp %0b got %0b", c.last, m_tlast);
						mismatches++;
					end
					if (m_tuser[0] !== c.conv) begin
						$error("converged exp %0b got %0b", c.conv, m_tuser[0]);
						mismatches++;
					end
					if (m_tdata[51:36] !== c.passes) begin
						$error("passes_run exp %0d got %0d", c.passes, m_tdata[51:36]);
						mismatches++;
					end
					if (m_tuser[1] !== c.zero) begin
						$error("zero_norm exp %0b got %0b", c.zero, m_tuser[1]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_WRITE)
					mat[s_tdata[3:0]][s_tdata[7:4]] = s_tdata[39:8];
				else
					predict_eigenvector();
			end
		end
		pending = eigen_q.size();
	end

endmodule

// ===== bench/tb_power_iteration_eigenvector.sv =====
`timescale 1ns / 100ps
module tb_power_iteration_eigenvector;
	import pie_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [30:0] cfg_wdata = '0;
	int          mismatches, pending;
	int          mode = 0;
	int          items = 0;
	int          holds_asked = 0, holds_done = 0, hold_left = 0;
	int          cycles = 0;
	int          cur_n = 16;
	bit          written[16][16];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	power_iteration_eigenvector uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	tb_pie_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata), .m_tlast(m_axis_tlast), .m_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 4000000) begin
			$display("FAIL");
			$finish;
		end
	end

	// sink side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 0;
			hold_left--;
		end else if (holds_asked != holds_done) begin
			holds_done++;
			hold_left = 3000;
			m_axis_tready <= 0;
		end else begin
			case (mode)
				0:       m_axis_tready <= $urandom_range(99) >= 52;
				1:       m_axis_tready <= $urandom_range(99) >= 34;
				default: m_axis_tready <= 1;
			endcase
		end
	end

	function automatic bit sender_idles();
		case (mode)
			0:       return $urandom_range(99) < 34;
			1:       return $urandom_range(99) < 52;
			default: return 0;
		endcase
	endfunction

	function automatic logic [31:0] rand_element();
		if ($urandom_range(3) == 0)
			return $urandom;
		return $urandom_range(32'h0004_0000) - 32'h0002_0000;
	endfunction

	task automatic send_item(opcode_t op, logic [3:0] r, logic [3:0] c, logic [31:0] v);
		while (sender_idles()) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {v, c, r};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (op == OP_WRITE)
			written[r][c] = 1;
		items++;
	endtask

	task automatic configure(logic [4:0] sz, logic [15:0] maxit, logic [30:0] prec);
		s_axis_tvalid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= CFG_SIZE;
		cfg_wdata <= {26'($urandom), sz};
		@(negedge clk);
		cfg_index <= CFG_MAXIT;
		cfg_wdata <= {15'($urandom), maxit};
		@(negedge clk);
		cfg_index <= CFG_PREC;
		cfg_wdata <= prec;
		@(negedge clk);
		cfg_we <= 0;
		cur_n = sz == 0 ? 1 : (sz > 16 ? 16 : sz);
	endtask

	// write any entry of the used block not yet loaded, then launch a run
	task automatic fill_and_start();
		for (int r = 0; r < cur_n; r++)
			for (int c = 0; c < cur_n; c++)
				if (!written[r][c])
					send_item(OP_WRITE, 4'(r), 4'(c), rand_element());
		send_item(OP_START, 4'($urandom), 4'($urandom), $urandom);
	endtask

	initial begin
		int          seq, n;
		logic [4:0]  sz;
		logic [15:0] maxit;
		logic [30:0] prec;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// extremes of the element range, default precision
		configure(2, 100, PREC_RST);
		send_item(OP_WRITE, 0, 0, 32'h7FFF_FFFF);
		send_item(OP_WRITE, 0, 1, 32'h8000_0000);
		send_item(OP_WRITE, 1, 0, 32'h0000_0000);
		send_item(OP_WRITE, 1, 1, 32'h0000_0001);
		send_item(OP_WRITE, 15, 15, 32'hFFFF_FFFF);
		fill_and_start();
		// zero norm
		configure(1, 100, 0);
		send_item(OP_WRITE, 0, 0, 32'h0);
		fill_and_start();
		// limits of 1 and 0: no pass at all
		configure(1, 1, 0);
		fill_and_start();
		configure(1, 0, 31'h4000_0000);
		fill_and_start();
		// size 0 acts as 1; largest iteration limit, converges at once
		configure(0, 16'hFFFF, 0);
		send_item(OP_WRITE, 0, 0, 32'h0001_0000);
		fill_and_start();
		// negative scalar flips sign each pass
		configure(1, 7, 31'h7FFF_FFFF);
		send_item(OP_WRITE, 0, 0, 32'hFFFF_0000);
		fill_and_start();

		seq = 0;
		while (items < 210) begin
			mode = items < 90 ? 0 : (items < 160 ? 1 : 2);
			if (seq == 0 || $urandom_range(4) < 3) begin
				if ($urandom_range(11) == 0)
					sz = 5'($urandom_range(16, 31));
				else
					sz = 5'($urandom_range(0, 4));
				n = sz == 0 ? 1 : (sz > 16 ? 16 : sz);
				maxit = n > 4 ? 16'($urandom_range(0, 4)) : 16'($urandom_range(0, 16));
				case ($urandom_range(3))
					0:       prec = 0;
					1:       prec = 31'h4000_0000;
					2:       prec = 31'($urandom_range(4096));
					default: prec = 31'($urandom);
				endcase
				configure(sz, maxit, prec);
			end
			repeat ($urandom_range(0, 5))
				send_item(OP_WRITE, 4'($urandom), 4'($urandom), rand_element());
			if (seq == 4)
				holds_asked++;
			fill_and_start();
			// keep offering items while the sink holds off
			if (seq == 4)
				repeat (6) send_item(OP_WRITE, 4'($urandom), 4'($urandom), rand_element());
			seq++;
		end

		s_axis_tvalid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
